@@ hdl/ordered_list_table_assert.svh @@
// Assertion helpers used by the checker file.
`ifndef ORDERED_LIST_TABLE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define OLT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered list table check failed");

// Next-cycle implication, quiet during reset.
`define OLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered list table check failed");

`endif

@@ hdl/olt_pkg.sv @@
`default_nettype none

package olt_pkg;

  // List size and derived widths
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Fixed field widths
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_APPEND = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4,
    OP_SEARCH = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // What a cell passes on along the locate chain
  typedef enum logic [1:0] {
    CHAIN_NONE,
    CHAIN_VALID,
    CHAIN_LESS
  } chain_t;

  // How the row moves on the update cycle
  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_OPEN,
    SHIFT_CLOSE
  } shift_t;

  typedef struct packed {
    chain_t chain;
    shift_t shift;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  // Index of the highest set bit, zero when none is set
  function automatic logic [IDX_W-1:0] last_one(input logic [CAPACITY-1:0] bits);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bits[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ hdl/olt_if.sv @@
`default_nettype none

// Request channel: one operation per beat
interface olt_req_if;
  logic                                valid;
  logic                                ready;
  logic [olt_pkg::MODE_W-1:0]          mode;
  logic signed [olt_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// Response channel: one result per beat
interface olt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [olt_pkg::STATUS_W-1:0]  status;
  logic                          found;
  logic [olt_pkg::POS_W-1:0]     position;
  logic [olt_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output status, output found, output position,
                  output count, input ready);
  modport sink   (input valid, input status, input found, input position,
                  input count, output ready);
endinterface

`default_nettype wire

@@ hdl/ordered_list_table.sv @@
// Flow: the request beat moves the table into its evaluation state, and
// the response is registered on the edge that completes the evaluation.
// New requests wait until the previous one completes; the cell row registers
// its compare flags on the accept edge, then resolves the locate chain and
// shifts the row on the completing edge, which waits while a response stalls.
// Reset: entry count cleared and channels idle; slot storage is not cleared.
`default_nettype none

module ordered_list_table (
  input  logic        clk,
  input  logic        rst,
  olt_req_if.sink     req,
  olt_rsp_if.source   rsp
);

  localparam int CAP = olt_pkg::CAPACITY;

  olt_pkg::state_t                     state;
  olt_pkg::state_t                     state_next;
  logic [olt_pkg::MODE_W-1:0]          mode_q;
  logic signed [olt_pkg::VALUE_W-1:0]  key_q;
  logic [olt_pkg::CNT_W-1:0]           count;
  logic [olt_pkg::CNT_W-1:0]           count_next;

  logic                                out_valid;
  olt_pkg::status_t                    out_status;
  logic                                out_found;
  logic [olt_pkg::POS_W-1:0]           out_position;
  logic [olt_pkg::COUNT_W-1:0]         out_count;

  logic                                accept;
  logic                                eval_done;
  logic                                full;
  logic                                empty;
  olt_pkg::status_t                    status_dec;
  olt_pkg::shift_t                     shift_dec;
  olt_pkg::chain_t                     chain_dec;
  logic                                found_dec;
  logic [olt_pkg::IDX_W-1:0]           pos_dec;
  olt_pkg::cell_ctl_t                  ctl;

  logic [CAP:0]                        pass;
  logic [CAP-1:0]                      valid;
  logic [CAP-1:0]                      hit;
  logic [CAP-1:0]                      match;
  logic signed [olt_pkg::VALUE_W-1:0]  cell_value [CAP];

  assign accept    = req.valid & req.ready;
  assign eval_done = (state == olt_pkg::S_EVAL) & (~out_valid | rsp.ready);
  assign full      = (count == olt_pkg::CNT_W'(CAP));
  assign empty     = (count == '0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      olt_pkg::S_IDLE: if (accept) state_next = olt_pkg::S_EVAL;
      olt_pkg::S_EVAL: if (eval_done) state_next = olt_pkg::S_IDLE;
      default:         state_next = olt_pkg::S_IDLE;
    endcase
  end

  // Handshake output
  always_comb begin
    req.ready = (state == olt_pkg::S_IDLE);
  end

  // Operation decode from the registered request and the row flags
  always_comb begin
    status_dec = olt_pkg::ST_OK;
    shift_dec  = olt_pkg::SHIFT_HOLD;
    chain_dec  = olt_pkg::CHAIN_NONE;
    found_dec  = 1'b0;
    pos_dec    = '0;
    count_next = count;
    case (olt_pkg::op_t'(mode_q))
      olt_pkg::OP_PUSH, olt_pkg::OP_APPEND, olt_pkg::OP_INSERT: begin
        if (olt_pkg::op_t'(mode_q) == olt_pkg::OP_APPEND) begin
          chain_dec = olt_pkg::CHAIN_VALID;
        end else if (olt_pkg::op_t'(mode_q) == olt_pkg::OP_INSERT) begin
          chain_dec = olt_pkg::CHAIN_LESS;
        end
        if (full) begin
          status_dec = olt_pkg::ST_FULL;
        end else begin
          shift_dec  = olt_pkg::SHIFT_OPEN;
          count_next = count + 1'b1;
        end
      end
      olt_pkg::OP_POP: begin
        if (empty) begin
          status_dec = olt_pkg::ST_EMPTY;
        end else begin
          shift_dec  = olt_pkg::SHIFT_CLOSE;
          count_next = count - 1'b1;
        end
      end
      olt_pkg::OP_DELETE: begin
        chain_dec = olt_pkg::CHAIN_LESS;
        if (|hit) begin
          shift_dec  = olt_pkg::SHIFT_CLOSE;
          count_next = count - 1'b1;
        end else begin
          status_dec = olt_pkg::ST_ABSENT;
        end
      end
      olt_pkg::OP_SEARCH: begin
        if (|match) begin
          found_dec = 1'b1;
          pos_dec   = olt_pkg::last_one(match);
        end else begin
          status_dec = olt_pkg::ST_ABSENT;
        end
      end
      default: begin
      end
    endcase
  end

  // Row control: the shift only happens on the edge that completes the item
  always_comb begin
    ctl.chain = chain_dec;
    ctl.shift = eval_done ? shift_dec : olt_pkg::SHIFT_HOLD;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= olt_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (eval_done) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and response payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= req.mode;
      key_q  <= req.value;
    end
    if (eval_done) begin
      out_status   <= status_dec;
      out_found    <= found_dec;
      out_position <= olt_pkg::POS_W'(pos_dec);
      out_count    <= olt_pkg::COUNT_W'(count_next);
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.found    = out_found;
  assign rsp.position = out_position;
  assign rsp.count    = out_count;

  // Cell row
  assign pass[0] = 1'b1;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic signed [olt_pkg::VALUE_W-1:0] left_value;
    logic signed [olt_pkg::VALUE_W-1:0] right_value;

    assign valid[i] = (count > olt_pkg::CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_value = key_q;
    end else begin : g_mid_left
      assign left_value = cell_value[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign right_value = key_q;
    end else begin : g_mid_right
      assign right_value = cell_value[i+1];
    end

    olt_cell u_cell (
      .clk         (clk),
      .capture     (accept),
      .cmp_key     (req.value),
      .wr_key      (key_q),
      .valid       (valid[i]),
      .ctl         (ctl),
      .pass_in     (pass[i]),
      .pass_out    (pass[i+1]),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i]),
      .hit         (hit[i]),
      .match       (match[i])
    );
  end

endmodule

`default_nettype wire

@@ hdl/olt_cell.sv @@
`default_nettype none

// One list slot: holds a value, compares it against the request key,
// takes part in the locate chain and shifts with its neighbors.
module olt_cell (
  input  logic                               clk,
  input  logic                               capture,
  input  logic signed [olt_pkg::VALUE_W-1:0] cmp_key,
  input  logic signed [olt_pkg::VALUE_W-1:0] wr_key,
  input  logic                               valid,
  input  olt_pkg::cell_ctl_t                 ctl,
  input  logic                               pass_in,
  output logic                               pass_out,
  input  logic signed [olt_pkg::VALUE_W-1:0] left_value,
  input  logic signed [olt_pkg::VALUE_W-1:0] right_value,
  output logic signed [olt_pkg::VALUE_W-1:0] value,
  output logic                               hit,
  output logic                               match
);

  logic less;
  logic eq;
  logic term;
  logic at_point;

  // Compare flags, taken when the request beat is accepted
  always_ff @(posedge clk) begin
    if (capture) begin
      less <= (value < cmp_key);
      eq   <= (value == cmp_key);
    end
  end

  // Locate chain: the first cell that does not pass is the operation point
  always_comb begin
    case (ctl.chain)
      olt_pkg::CHAIN_VALID: term = valid;
      olt_pkg::CHAIN_LESS:  term = valid & less;
      default:              term = 1'b0;
    endcase
  end

  assign pass_out = pass_in & term;
  assign at_point = pass_in & ~term;
  assign hit      = at_point & valid & eq;
  assign match    = valid & eq;

  // Open a slot at the point or close it, moving the tail by one
  always_ff @(posedge clk) begin
    case (ctl.shift)
      olt_pkg::SHIFT_OPEN: begin
        if (at_point) begin
          value <= wr_key;
        end else if (!pass_in) begin
          value <= left_value;
        end
      end
      olt_pkg::SHIFT_CLOSE: begin
        // the point and every cell behind it take the right neighbor
        if (!pass_out) begin
          value <= right_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/olt_checker.sv @@
`default_nettype none
`include "ordered_list_table_assert.svh"

// Port-level checks on the response channel
module olt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [olt_pkg::STATUS_W-1:0]  status,
  input logic                          found,
  input logic [olt_pkg::POS_W-1:0]     position,
  input logic [olt_pkg::COUNT_W-1:0]   count
);

  // A stalled response beat holds
  `OLT_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && ($stable({status, found, position, count})))

  // A hit is only reported with an ok status
  `OLT_ASSERT_IMPL(a_found_ok, clk, rst, rsp_valid && found, status == olt_pkg::ST_OK)

  // Without a hit the position stays at zero
  `OLT_ASSERT_IMPL(a_pos_zero, clk, rst, rsp_valid && !found, position == '0)

  // Full status comes only with a full list
  `OLT_ASSERT_IMPL(a_full_count, clk, rst, rsp_valid && status == olt_pkg::ST_FULL, count == olt_pkg::COUNT_W'(olt_pkg::CAPACITY))

  // Empty status comes only with an empty list
  `OLT_ASSERT_IMPL(a_empty_count, clk, rst, rsp_valid && status == olt_pkg::ST_EMPTY, count == '0)

endmodule

bind ordered_list_table olt_checker u_olt_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .found     (rsp.found),
  .position  (rsp.position),
  .count     (rsp.count)
);

`default_nettype wire
